// ----- hw/rtl/pexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_pkg: shared types and constants of the expression evaluator
// Holds the operation codes, the queue item and stack frame types, the
// character codes and the status codes.
// ----------------------------------------------------------------------------
package pexp_pkg;

  // Operation decoded from one input character.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIGIT,
    OP_PLUS,
    OP_MINUS,
    OP_OPEN,
    OP_CLOSE
  } op_t;

  // One classified character as it travels from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } item_t;

  // One saved nesting level: outer sum and the sign pending before '('.
  typedef struct packed {
    logic        neg;
    logic [31:0] sum;
  } frame_t;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [31:0] RADIX = 32'd10;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;
  localparam logic [1:0] ST_UNCLOSED  = 2'd3;

endpackage

// ----- hw/rtl/paren_expression_evaluator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paren_expression_evaluator_unit: add/subtract expression evaluator
// Evaluates a character stream of digits, '+', '-', '(' and ')' with 32-bit
// wrapping arithmetic and emits the sum and a status at the end of each
// expression.
//
//   Channel  Dir  Payload                          Transfer
//   in_      in   tdata[7:0] ch, tlast last        one per character
//   out_     out  tdata[31:0] value, tuser status  one per expression
//
// Sustains one character per cycle while no held result stalls a last
// character; a result is offered from the output register, reached through
// the queue, after the transfer of its last character.
// The rate is set by the execute step of the back end, which for each item
// updates the sums and the frame stack RAM (one write, one prefetch read).
// A two-entry queue decouples classification from execution; a result held
// in the output register stalls only the next last character.
// Synchronous active-low reset clears evaluation and control state, not data;
// the stack RAM needs no clearing pass since only written frames are read.
// ----------------------------------------------------------------------------
module paren_expression_evaluator_unit #(
  parameter int NEST_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value (signed)
  output logic [1:0]  out_tuser   // [1:0] status
);

  import pexp_pkg::*;

  logic  fr_valid;
  logic  fr_ready;
  item_t fr_item;
  logic  bk_valid;
  logic  bk_ready;
  item_t bk_item;

  // Classifier.
  pexp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (fr_valid),
    .q_ready   (fr_ready),
    .q_item    (fr_item)
  );

  // Queue between the two halves.
  pexp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_item  (bk_item)
  );

  // Evaluation engine.
  pexp_back #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (bk_valid),
    .q_ready    (bk_ready),
    .q_item     (bk_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hw/rtl/pexp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and shows the
// old contents when the same address is written in the same cycle.
// ----------------------------------------------------------------------------
module pexp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ----- hw/rtl/pexp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_front: character classifier
// Turns each input character into an operation code with its digit value
// and passes it on to the queue under the stream handshake.
// ----------------------------------------------------------------------------
module pexp_front (
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tlast,
  output logic           q_valid,
  input  logic           q_ready,
  output pexp_pkg::item_t q_item
);

  import pexp_pkg::*;

  logic [7:0] digit_off;

  assign digit_off = in_tdata - CH_ZERO;

  // Classify the character; every byte outside the alphabet becomes a no-op.
  always_comb begin
    q_item.op    = OP_NOP;
    q_item.digit = digit_off[3:0];
    q_item.last  = in_tlast;
    if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
      q_item.op = OP_DIGIT;
    end else if (in_tdata == CH_PLUS) begin
      q_item.op = OP_PLUS;
    end else if (in_tdata == CH_MINUS) begin
      q_item.op = OP_MINUS;
    end else if (in_tdata == CH_OPEN) begin
      q_item.op = OP_OPEN;
    end else if (in_tdata == CH_CLOSE) begin
      q_item.op = OP_CLOSE;
    end
  end

  assign q_valid   = in_tvalid;
  assign in_tready = q_ready;

endmodule

// ----- hw/rtl/pexp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_fifo: two-entry queue between front end and back end
// Register-based FIFO that takes a push and a pop in the same cycle, so
// both sides run at one item per cycle when not stalled, and stall independently.
// ----------------------------------------------------------------------------
module pexp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  pexp_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output pexp_pkg::item_t rd_item
);

  import pexp_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/pexp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_back: evaluation engine
// Executes one operation per cycle unless a last item waits on a held result,
// working on the running sum, the current number and the frame stack, and
// holds the result in an output register. The top frame lives in registers;
// deeper frames sit in a RAM read ahead so a ')' always finds its next frame.
// ----------------------------------------------------------------------------
module pexp_back #(
  parameter int NEST_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  pexp_pkg::item_t q_item,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic [1:0]      out_tuser
);

  import pexp_pkg::*;

  localparam int CW = $clog2(NEST_DEPTH + 1);
  localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int FW = $bits(frame_t);

  logic [31:0]   sum_r,  sum_nxt;
  logic [31:0]   cur_r,  cur_nxt;
  logic          neg_r,  neg_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [1:0]    err_r,  err_nxt;
  frame_t        top_r,  top_nxt;
  logic          hit_r,  hit_nxt;
  frame_t        byp_r;
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  logic [1:0]    out_status_r;

  logic          go;
  logic [31:0]   fold;
  logic [31:0]   result;
  logic [1:0]    status;
  frame_t        pop_frame;
  logic [FW-1:0] rd_data;
  logic          wr_en;
  frame_t        wr_data;
  logic [CW:0]   wr_full;
  logic [CW:0]   rd_full;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // A last item needs the output register free; other items never wait.
  assign go      = q_valid && !(q_item.last && out_valid_r && !out_tready);
  assign q_ready = go;

  // Stack addressing: frame k (0-based) of the count is in RAM at k when it
  // is not the top; the next top is prefetched from count_nxt - 2.
  assign wr_full = {1'b0, cnt_r} - (CW + 1)'(1);
  assign rd_full = {1'b0, cnt_nxt} - (CW + 1)'(2);
  assign wr_addr = wr_full[AW-1:0];
  assign rd_addr = rd_full[AW-1:0];
  assign wr_data = top_r;
  assign hit_nxt = wr_en && (wr_addr == rd_addr);

  assign pop_frame = hit_r ? byp_r : frame_t'(rd_data);
  assign fold      = neg_r ? (sum_r - cur_r) : (sum_r + cur_r);

  // Execute one operation, then close the expression on a last item.
  always_comb begin
    sum_nxt = sum_r;
    cur_nxt = cur_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    top_nxt = top_r;
    wr_en   = 1'b0;
    if (go) begin
      case (q_item.op)
        OP_DIGIT: begin
          cur_nxt = (cur_r * RADIX) + {28'd0, q_item.digit};
        end
        OP_PLUS, OP_MINUS: begin
          sum_nxt = fold;
          cur_nxt = 32'd0;
          neg_nxt = (q_item.op == OP_MINUS);
        end
        OP_OPEN: begin
          if (cnt_r < CW'(NEST_DEPTH)) begin
            wr_en   = (cnt_r != '0);
            top_nxt = '{neg: neg_r, sum: sum_r};
            cnt_nxt = cnt_r + CW'(1);
            sum_nxt = 32'd0;
            neg_nxt = 1'b0;
          end else if (err_r == ST_OK) begin
            err_nxt = ST_OVERFLOW;
          end
        end
        OP_CLOSE: begin
          cur_nxt = 32'd0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CW'(1);
            top_nxt = pop_frame;
            sum_nxt = top_r.neg ? (top_r.sum - fold) : (top_r.sum + fold);
          end else begin
            sum_nxt = fold;
            if (err_r == ST_OK) begin
              err_nxt = ST_UNMATCHED;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Final fold and status of the expression.
    result = neg_nxt ? (sum_nxt - cur_nxt) : (sum_nxt + cur_nxt);
    if (err_nxt == ST_OK && cnt_nxt != '0) begin
      status = ST_UNCLOSED;
    end else begin
      status = err_nxt;
    end

    if (go && q_item.last) begin
      sum_nxt = 32'd0;
      cur_nxt = 32'd0;
      neg_nxt = 1'b0;
      cnt_nxt = '0;
      err_nxt = ST_OK;
    end
  end

  // Evaluation state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 32'd0;
      cur_r <= 32'd0;
      neg_r <= 1'b0;
      cnt_r <= '0;
      err_r <= ST_OK;
      hit_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cur_r <= cur_nxt;
      neg_r <= neg_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Top frame and write bypass for a read of the address just written.
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    byp_r <= wr_data;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && q_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && q_item.last) begin
      out_value_r  <= result;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Frames below the top.
  pexp_ram #(
    .WIDTH  (FW),
    .DEPTH  (NEST_DEPTH),
    .ADDR_W (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- hw/rtl/pexp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_checker: port-level checks of the evaluator
// Watches the top-level ports for reset behavior and output stalls.
// ----------------------------------------------------------------------------
module pexp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Reset leaves no result pending.
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // Reset empties the queue, so the input side is free right after it.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value and status.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind paren_expression_evaluator_unit pexp_checker u_pexp_checker (.*);
